### rtl/core/spq_pkg.sv
package spq_pkg;

	localparam int DEPTH = 8;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int HELD_W = 4;
	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;
	localparam int ORD_W = 16;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} spq_cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} spq_state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
		logic [ORD_W-1:0]         ord;
	} spq_entry_t;

	typedef struct packed {
		spq_cmd_code_t            command;
		logic signed [DATA_W-1:0] item_data;
		logic [PRIO_W-1:0]        item_priority;
		logic [ORD_W-1:0]         item_order;
	} spq_cmd_t;

	typedef struct packed {
		logic step;
	} spq_ctl_t;

endpackage

### rtl/core/spq_cmd_if.sv
interface spq_cmd_if;
	logic                               valid;
	logic                               ready;
	logic                               command;
	logic signed [spq_pkg::DATA_W-1:0]  item_data;
	logic [spq_pkg::PRIO_W-1:0]         item_priority;
	logic [spq_pkg::ORD_W-1:0]          item_order;

	modport source (output valid, command, item_data, item_priority, item_order, input ready);
	modport sink (input valid, command, item_data, item_priority, item_order, output ready);
endinterface

### rtl/core/spq_rsp_if.sv
interface spq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         status;
	logic signed [spq_pkg::DATA_W-1:0]  removed_data;
	logic [spq_pkg::HELD_W-1:0]         entries_held;

	modport source (output valid, status, removed_data, entries_held, input ready);
	modport sink (input valid, status, removed_data, entries_held, output ready);
endinterface

### rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue of DEPTH entries. Each command word is either an insert (data,
// priority, order tag) or a remove of the head, and yields exactly one response word
// with a status, the removed data and the entry count. Entries leave in ascending
// priority, then ascending order tag, then arrival order. A command is accepted every
// cycle unless the pending response is stalled; its response appears in the output register
// on the next cycle, and a new command is accepted in the same cycle that the pending
// response is taken. The sorted insert compares the new key to all held entries in parallel.
module sorted_priority_queue_core (
	input logic       clk,
	input logic       arst_n,
	spq_cmd_if.sink   cmd,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	spq_ctl_t    ctl;
	spq_cmd_t    cmd_word;
	spq_status_t status;

	assign cmd_word = '{command: spq_cmd_code_t'(cmd.command), item_data: cmd.item_data,
		item_priority: cmd.item_priority, item_order: cmd.item_order};

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.ctl      (ctl)
	);

	spq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cmd_word    (cmd_word),
		.status      (status),
		.removed_data(rsp.removed_data),
		.entries_held(rsp.entries_held)
	);

	assign rsp.status = 2'(status);

endmodule

### rtl/core/spq_ctrl.sv
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output spq_pkg::spq_ctl_t ctl
);
	import spq_pkg::*;

	spq_state_t state_q;
	spq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		ctl.step = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ctl.step = in_valid;
				if (in_valid) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				ctl.step = in_valid && out_ready;
				if (out_ready && !in_valid) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/spq_dpath.sv
module spq_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spq_pkg::spq_ctl_t                 ctl,
	input  spq_pkg::spq_cmd_t                 cmd_word,
	output spq_pkg::spq_status_t              status,
	output logic signed [spq_pkg::DATA_W-1:0] removed_data,
	output logic [spq_pkg::HELD_W-1:0]        entries_held
);
	import spq_pkg::*;

	spq_entry_t              ent_q [DEPTH];
	spq_entry_t              ent_d [DEPTH];
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cnt_d;
	logic [DEPTH-1:0]        gt;
	spq_entry_t              fresh;
	spq_status_t             status_d;
	logic signed [DATA_W-1:0] removed_d;
	spq_status_t             status_q;
	logic signed [DATA_W-1:0] removed_q;
	logic [HELD_W-1:0]       held_q;

	assign fresh = '{data: cmd_word.item_data, prio: cmd_word.item_priority,
		ord: cmd_word.item_order};

	// Held entries are sorted, so the entries whose key exceeds the new one form a tail.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_W'(i) < cnt_q) &&
				({ent_q[i].prio, ent_q[i].ord} > {fresh.prio, fresh.ord});
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_d[i] = ent_q[i];
		end
		cnt_d = cnt_q;
		status_d = ST_OK;
		removed_d = '0;
		case (cmd_word.command)
			CMD_INSERT: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (gt[i] || (CNT_W'(i) == cnt_q)) begin
							ent_d[i] = fresh;
						end
					end
					for (int i = 1; i < DEPTH; i++) begin
						if (gt[i-1]) begin
							ent_d[i] = ent_q[i-1];
						end
					end
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					removed_d = ent_q[0].data;
					for (int i = 0; i < DEPTH - 1; i++) begin
						ent_d[i] = ent_q[i+1];
					end
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			for (int i = 0; i < DEPTH; i++) begin
				ent_q[i] <= ent_d[i];
			end
			status_q <= status_d;
			removed_q <= removed_d;
			held_q <= HELD_W'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_d;
		end
	end

	assign status = status_q;
	assign removed_data = removed_q;
	assign entries_held = held_q;

endmodule

### rtl/core/spq_checker.sv
module spq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [1:0]                        status,
	input logic signed [spq_pkg::DATA_W-1:0] removed_data
);
	import spq_pkg::*;

	// Every accepted command word leaves a response word pending on the next cycle.
	a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted command gave no response");

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("command accepted while response is stalled");

	a_data_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 2'(ST_OK)) |-> removed_data == '0)
		else $error("removed data not zero on refused command");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(removed_data))
		else $error("stalled response changed");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.removed_data(rsp.removed_data)
);
